// ----- sv/hkrb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hkrb_pkg
// Shared constants, sequencer states and control/status structs for the
// HID key report buffer.
// ----------------------------------------------------------------------------
package hkrb_pkg;

    localparam int SLOT_COUNT_DEF = 6;
    localparam int REPORT_SLOTS   = 6;

    localparam logic [7:0] MOD_FIRST = 8'he0;
    localparam logic [7:0] MOD_END   = 8'he8;
    localparam logic [7:0] DUMMY_KEY = 8'hff;
    localparam logic [7:0] NO_KEY    = 8'h00;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_COMMIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic decide;
        logic scan;
        logic commit;
        logic emit;
    } ctrl_t;

    typedef struct packed {
        logic need_scan;
        logic scan_last;
    } stat_t;

endpackage : hkrb_pkg
`default_nettype wire

// ----- sv/hkrb_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hkrb_ctrl
// Sequencer: accepts one transaction, steps the shared slot compare over the
// slots and commits the new slot list if needed; hands the report to output.
// ----------------------------------------------------------------------------
module hkrb_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  wire logic           out_stall,
    input  wire hkrb_pkg::stat_t stat,
    output hkrb_pkg::ctrl_t     ctrl
);
    import hkrb_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = stat.need_scan ? ST_SCAN : ST_EMIT;
            end
            ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl     = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                ctrl.accept = in_valid;
            end
            ST_DECIDE:
            begin
                ctrl.decide = 1'b1;
            end
            ST_SCAN:
            begin
                ctrl.scan = 1'b1;
            end
            ST_COMMIT:
            begin
                ctrl.commit = 1'b1;
            end
            ST_EMIT:
            begin
                ctrl.emit = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule : hkrb_ctrl
`default_nettype wire

// ----- sv/hkrb_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hkrb_datapath
// Key slots, modifier byte, scratch slot list and the single slot compare
// that the sequencer walks over the slots, one slot per cycle.
// ----------------------------------------------------------------------------
module hkrb_datapath #(
    parameter int SLOT_COUNT = hkrb_pkg::SLOT_COUNT_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [7:0]      key_code,
    input  wire logic            pressed,
    input  wire hkrb_pkg::ctrl_t ctrl,
    output hkrb_pkg::stat_t      stat,
    output logic [7:0]           modifier_byte,
    output logic [7:0]           slot_0,
    output logic [7:0]           slot_1,
    output logic [7:0]           slot_2,
    output logic [7:0]           slot_3,
    output logic [7:0]           slot_4,
    output logic [7:0]           slot_5,
    output logic                 changed
);
    import hkrb_pkg::*;

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int PW = $clog2(SLOT_COUNT + 1);

    logic [7:0]    code_reg;
    logic          press_reg;
    logic [7:0]    mod_reg;
    logic [7:0]    mod_next;
    logic [7:0]    slot_reg [SLOT_COUNT];
    logic [7:0]    slot_next [SLOT_COUNT];
    logic [7:0]    work_reg [SLOT_COUNT];
    logic [7:0]    work_next [SLOT_COUNT];
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;
    logic [PW-1:0] wptr_reg;
    logic [PW-1:0] wptr_next;
    logic          chg_reg;
    logic          chg_next;

    logic [7:0]    out_mod_reg;
    logic [7:0]    out_slot_reg [REPORT_SLOTS];
    logic          out_chg_reg;

    logic          hit;
    logic          ignored;
    logic          is_mod;
    logic [7:0]    mod_bit;

    // The one shared compare: the addressed slot against the event's code.
    // During the decide step the address is zero, so it checks the front slot.
    assign hit     = (slot_reg[idx_reg] == code_reg);
    assign ignored = (code_reg == NO_KEY) || (code_reg == DUMMY_KEY);
    assign is_mod  = (code_reg >= MOD_FIRST) && (code_reg < MOD_END);
    assign mod_bit = 8'b1 << code_reg[2:0];

    assign stat.need_scan = !ignored && !is_mod && !(press_reg && hit);
    assign stat.scan_last = (idx_reg == IW'(SLOT_COUNT - 1));

    always_comb
    begin
        mod_next  = mod_reg;
        slot_next = slot_reg;
        work_next = work_reg;
        idx_next  = idx_reg;
        wptr_next = wptr_reg;
        chg_next  = chg_reg;

        if (ctrl.decide)
        begin
            chg_next = 1'b0;
            idx_next = '0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                work_next[i] = 8'h00;
            end
            if (press_reg)
            begin
                work_next[0] = code_reg;
                wptr_next    = PW'(1);
            end
            else
            begin
                wptr_next = '0;
            end
            if (!ignored && is_mod)
            begin
                if (press_reg && ((mod_reg & mod_bit) == 8'h00))
                begin
                    mod_next = mod_reg | mod_bit;
                    chg_next = 1'b1;
                end
                else if (!press_reg && ((mod_reg & mod_bit) != 8'h00))
                begin
                    mod_next = mod_reg & ~mod_bit;
                    chg_next = 1'b1;
                end
            end
            else if (stat.need_scan && press_reg)
            begin
                chg_next = 1'b1;
            end
        end

        if (ctrl.scan)
        begin
            // Copies of the code are dropped; everything else is packed toward
            // the front, and whatever no longer fits falls off the end.
            if (hit)
            begin
                chg_next = 1'b1;
            end
            else if (wptr_reg < PW'(SLOT_COUNT))
            begin
                work_next[wptr_reg[IW-1:0]] = slot_reg[idx_reg];
                wptr_next = wptr_reg + PW'(1);
            end
            idx_next = stat.scan_last ? '0 : idx_reg + IW'(1);
        end

        if (ctrl.commit)
        begin
            slot_next = work_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg <= 8'h00;
            idx_reg <= '0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_reg[i] <= 8'h00;
            end
        end
        else
        begin
            mod_reg  <= mod_next;
            idx_reg  <= idx_next;
            slot_reg <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            code_reg  <= key_code;
            press_reg <= pressed;
        end
        work_reg <= work_next;
        wptr_reg <= wptr_next;
        chg_reg  <= chg_next;
        if (ctrl.emit)
        begin
            out_mod_reg <= mod_reg;
            out_chg_reg <= chg_reg;
        end
    end

    for (genvar j = 0; j < REPORT_SLOTS; j++)
    begin : g_out_slot
        if (j < SLOT_COUNT)
        begin : g_held
            always_ff @(posedge clk)
            begin
                if (ctrl.emit)
                begin
                    out_slot_reg[j] <= slot_reg[j];
                end
            end
        end
        else
        begin : g_empty
            assign out_slot_reg[j] = 8'h00;
        end
    end

    assign modifier_byte = out_mod_reg;
    assign slot_0        = out_slot_reg[0];
    assign slot_1        = out_slot_reg[1];
    assign slot_2        = out_slot_reg[2];
    assign slot_3        = out_slot_reg[3];
    assign slot_4        = out_slot_reg[4];
    assign slot_5        = out_slot_reg[5];
    assign changed       = out_chg_reg;

endmodule : hkrb_datapath
`default_nettype wire

// ----- sv/hid_key_report_buffer_top.sv -----
`default_nettype none
// Modifier, ignored and repeated-front events pass from acceptance through the
// decide and emit states to the report; other key events also pass through the
// scan state, where the single slot compare walks the slots one per cycle, and
// the commit state. A new transaction is taken only once the last one is done;
// the input is stalled while an event is in work, and a waiting report holds
// the sequencer.
// Reset (rst_n low, asynchronous): the held modifier byte and all key slots clear.
// ----------------------------------------------------------------------------
// hid_key_report_buffer_top
// Boot-keyboard style report keeper: modifier byte plus newest-first key
// slots, updated by key press and release events.
// ----------------------------------------------------------------------------
module hid_key_report_buffer_top #(
    parameter int SLOT_COUNT = hkrb_pkg::SLOT_COUNT_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] key_code,
    input  wire logic       pressed,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      modifier_byte,
    output logic [7:0]      slot_0,
    output logic [7:0]      slot_1,
    output logic [7:0]      slot_2,
    output logic [7:0]      slot_3,
    output logic [7:0]      slot_4,
    output logic [7:0]      slot_5,
    output logic            changed
);
    import hkrb_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    hkrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    hkrb_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .key_code      (key_code),
        .pressed       (pressed),
        .ctrl          (ctrl),
        .stat          (stat),
        .modifier_byte (modifier_byte),
        .slot_0        (slot_0),
        .slot_1        (slot_1),
        .slot_2        (slot_2),
        .slot_3        (slot_3),
        .slot_4        (slot_4),
        .slot_5        (slot_5),
        .changed       (changed)
    );

endmodule : hid_key_report_buffer_top
`default_nettype wire

// ----- verif/key_report_sb_pkg.sv -----
// ----------------------------------------------------------------------------
// key_report_sb_pkg
// Scoreboard for the HID key report buffer. It keeps its own copy of the
// modifier byte and the newest-first key slots. Each accepted key event is
// folded into that copy, and the resulting report is queued. Each report the
// block emits is checked against the oldest queued one.
// ----------------------------------------------------------------------------
package key_report_sb_pkg;

    import hkrb_pkg::*;

    typedef struct packed {
        logic [7:0]                   mods;
        logic [REPORT_SLOTS-1:0][7:0] keys;
        logic                         chg;
    } key_report_t;

    class key_report_scoreboard;

        key_report_t expected_reports[$];
        int          mismatch_count;
        logic [7:0]  mod_state;
        logic [7:0]  held [REPORT_SLOTS];

        function new();
            mismatch_count = 0;
            mod_state      = NO_KEY;
            foreach (held[i])
            begin
                held[i] = NO_KEY;
            end
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        // Removes every copy of code and closes up the gaps toward slot 0.
        function bit drop_key(logic [7:0] code);
            logic [7:0] kept [REPORT_SLOTS];
            int         n;
            bit         hit;
            n   = 0;
            hit = 1'b0;
            for (int i = 0; i < REPORT_SLOTS; i++)
            begin
                if (held[i] == code)
                begin
                    hit = 1'b1;
                end
                else
                begin
                    kept[n] = held[i];
                    n++;
                end
            end
            for (int i = 0; i < REPORT_SLOTS; i++)
            begin
                held[i] = (i < n) ? kept[i] : NO_KEY;
            end
            return hit;
        endfunction

        function key_report_t apply_key_event(logic [7:0] code, logic press);
            key_report_t rpt;
            bit          is_mod;
            logic [7:0]  mask;
            rpt.chg = 1'b0;
            if (code != NO_KEY && code != DUMMY_KEY)
            begin
                is_mod = (code >= MOD_FIRST) && (code < MOD_END);
                mask   = is_mod ? (8'h01 << (code - MOD_FIRST)) : 8'h00;
                if (press)
                begin
                    if (is_mod)
                    begin
                        if ((mod_state & mask) == 8'h00)
                        begin
                            mod_state = mod_state | mask;
                            rpt.chg   = 1'b1;
                        end
                    end
                    else if (held[0] != code)
                    begin
                        void'(drop_key(code));
                        for (int i = REPORT_SLOTS - 1; i > 0; i--)
                        begin
                            held[i] = held[i-1];
                        end
                        held[0] = code;
                        rpt.chg = 1'b1;
                    end
                end
                else
                begin
                    if (is_mod && (mod_state & mask) != 8'h00)
                    begin
                        mod_state = mod_state & ~mask;
                        rpt.chg   = 1'b1;
                    end
                    if (drop_key(code))
                    begin
                        rpt.chg = 1'b1;
                    end
                end
            end
            rpt.mods = mod_state;
            for (int i = 0; i < REPORT_SLOTS; i++)
            begin
                rpt.keys[i] = held[i];
            end
            return rpt;
        endfunction

        function void note_event(logic [7:0] code, logic press);
            expected_reports.push_back(apply_key_event(code, press));
        endfunction

        function void check_report(key_report_t act);
            key_report_t exp_rpt;
            if (expected_reports.size() == 0)
            begin
                $error("report emitted with no transaction pending");
                mismatch_count++;
                return;
            end
            exp_rpt = expected_reports.pop_front();
            if (act.mods !== exp_rpt.mods)
            begin
                $error("modifier_byte: expected %02h, actual %02h", exp_rpt.mods, act.mods);
                mismatch_count++;
            end
            for (int i = 0; i < REPORT_SLOTS; i++)
            begin
                if (act.keys[i] !== exp_rpt.keys[i])
                begin
                    $error("slot_%0d: expected %02h, actual %02h",
                           i, exp_rpt.keys[i], act.keys[i]);
                    mismatch_count++;
                end
            end
            if (act.chg !== exp_rpt.chg)
            begin
                $error("changed: expected %0b, actual %0b", exp_rpt.chg, act.chg);
                mismatch_count++;
            end
        endfunction

    endclass

endpackage : key_report_sb_pkg

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives key press and release events into the HID key report buffer, first
// a directed list of corner cases and then bursts of random events drawn
// mostly from a small key pool, under random input gaps and output stalls.
// Every emitted report is checked against the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import hkrb_pkg::*;
    import key_report_sb_pkg::*;

    localparam int RANDOM_EVENTS = 600;
    localparam int LONG_HOLD     = 400;
    localparam int TAIL_CYCLES   = 4 * (SLOT_COUNT_DEF + 4);

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] key_code  = 8'h00;
    logic       pressed   = 1'b0;
    logic       out_stall = 1'b0;

    logic       in_stall;
    logic       out_valid;
    logic [7:0] modifier_byte;
    logic [7:0] slot_0;
    logic [7:0] slot_1;
    logic [7:0] slot_2;
    logic [7:0] slot_3;
    logic [7:0] slot_4;
    logic [7:0] slot_5;
    logic       changed;

    bit hold_go = 1'b0;

    key_report_scoreboard sb = new();

    // Directed events as {pressed, key_code}.
    logic [8:0] directed_events [25] = '{
        {1'b1, 8'h00}, {1'b0, 8'hff}, {1'b1, 8'he0}, {1'b1, 8'he0}, {1'b1, 8'he7},
        {1'b0, 8'he3}, {1'b0, 8'he0}, {1'b1, 8'h04}, {1'b1, 8'h04}, {1'b1, 8'h05},
        {1'b1, 8'h06}, {1'b1, 8'h07}, {1'b1, 8'h08}, {1'b1, 8'h09}, {1'b1, 8'h0a},
        {1'b1, 8'h07}, {1'b0, 8'h04}, {1'b0, 8'h08}, {1'b1, 8'hdf}, {1'b1, 8'he8},
        {1'b1, 8'hfe}, {1'b1, 8'h01}, {1'b0, 8'he7}, {1'b1, 8'hff}, {1'b0, 8'h00}
    };

    hid_key_report_buffer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .key_code      (key_code),
        .pressed       (pressed),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .modifier_byte (modifier_byte),
        .slot_0        (slot_0),
        .slot_1        (slot_1),
        .slot_2        (slot_2),
        .slot_3        (slot_3),
        .slot_4        (slot_4),
        .slot_5        (slot_5),
        .changed       (changed)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Called at a rising edge; returns at the edge where the transaction
    // was accepted, with valid still high.
    task automatic send_event(input logic [7:0] code, input logic press);
        in_valid <= 1'b1;
        key_code <= code;
        pressed  <= press;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        sb.note_event(code, press);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain_reports();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (sb.pending() != 0);
    endtask

    // Mostly a small pool of keys, wider than the slot count so the oldest
    // key gets pushed out, plus modifiers, arbitrary codes and ignored codes.
    task automatic pick_event(output logic [7:0] code, output logic press);
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            code  = 8'h04 + 8'($urandom_range(0, 9));
            press = ($urandom_range(0, 2) != 0);
        end
        else if (r < 75)
        begin
            code  = MOD_FIRST + 8'($urandom_range(0, 7));
            press = 1'($urandom_range(0, 1));
        end
        else if (r < 95)
        begin
            code  = 8'($urandom_range(0, 255));
            press = 1'($urandom_range(0, 1));
        end
        else
        begin
            code  = $urandom_range(0, 1) ? DUMMY_KEY : NO_KEY;
            press = 1'($urandom_range(0, 1));
        end
    endtask

    always @(posedge clk)
    begin
        key_report_t act;
        if (rst_n && out_valid && !out_stall)
        begin
            act.mods    = modifier_byte;
            act.keys[0] = slot_0;
            act.keys[1] = slot_1;
            act.keys[2] = slot_2;
            act.keys[3] = slot_3;
            act.keys[4] = slot_4;
            act.keys[5] = slot_5;
            act.chg     = changed;
            sb.check_report(act);
        end
    end

    // Receiver: runs of free flow, light stalls and heavy stalls, plus one
    // long hold-off once the random phase begins.
    initial
    begin
        int  run_left;
        int  mode;
        int  hold_left;
        bit  hold_done;
        run_left  = 0;
        mode      = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_go && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                out_stall <= 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    run_left = $urandom_range(5, 60);
                    mode     = $urandom_range(0, 2);
                end
                run_left--;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    initial
    begin
        logic [7:0] code;
        logic       press;
        int         sent;
        int         burst;
        int         sel;
        bit         paused;
        sent   = 0;
        paused = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_events[i])
        begin
            send_event(directed_events[i][7:0], directed_events[i][8]);
            idle_cycles($urandom_range(0, 2));
        end
        drain_reports();

        hold_go = 1'b1;
        while (sent < RANDOM_EVENTS)
        begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst; b++)
            begin
                pick_event(code, press);
                send_event(code, press);
                sent++;
            end
            if (sent >= RANDOM_EVENTS / 2 && !paused)
            begin
                paused = 1'b1;
                drain_reports();
            end
            else
            begin
                sel = $urandom_range(0, 3);
                if (sel != 0)
                begin
                    idle_cycles($urandom_range(1, (sel == 3) ? 30 : 6));
                end
            end
        end

        drain_reports();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin
        #1ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule : tb_top

// ----- files.f -----
sv/hkrb_pkg.sv
sv/hkrb_ctrl.sv
sv/hkrb_datapath.sv
sv/hid_key_report_buffer_top.sv
verif/key_report_sb_pkg.sv
verif/tb_top.sv
